### hw/rtl/pcda_pkg.sv
// ---------------------------------------------------------------------------
// pcda_pkg: shared types and constants for the posture alarm block
// Verdict, voice and report codes, configuration layout and result word.
// ---------------------------------------------------------------------------
package pcda_pkg;

    // time arithmetic width, intervals wrap modulo 2^TIME_BITS
    localparam int TIME_BITS = 32;

    localparam int NOW_BITS    = 32;
    localparam int VERDICT_BITS = 2;
    localparam int IN_BITS     = VERDICT_BITS + NOW_BITS;
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // register reset values
    localparam logic [7:0]  MIN_HOLD_RESET   = 8'd3;
    localparam logic [15:0] BAD_ALARM_RESET  = 16'd10;
    localparam logic [15:0] REPEAT_RESET     = 16'd10;
    localparam logic [15:0] AWAY_ALARM_RESET = 16'd60;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_BAD    = 2'd1,
        CLS_AWAY   = 2'd2,
        CLS_OTHER  = 2'd3
    } class_t;

    typedef enum logic [2:0] {
        VOICE_NONE     = 3'd0,
        VOICE_WARN     = 3'd1,
        VOICE_PRAISE   = 3'd2,
        VOICE_REAPPEAR = 3'd3,
        VOICE_AWAY     = 3'd4,
        VOICE_SLEEP    = 3'd5
    } voice_t;

    typedef enum logic [1:0] {
        REPORT_NONE = 2'd0,
        REPORT_BACK = 2'd1,
        REPORT_BAD  = 2'd2,
        REPORT_AWAY = 2'd3
    } report_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_HOLD   = 2'd0,
        CFG_BAD_ALARM  = 2'd1,
        CFG_REPEAT     = 2'd2,
        CFG_AWAY_ALARM = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  min_hold_secs;
        logic [15:0] bad_alarm_secs;
        logic [15:0] repeat_alarm_secs;
        logic [15:0] away_alarm_secs;
    } cfg_t;

    // declared from the top bit down, so confirmed_change lands in bit 0
    typedef struct packed {
        logic    shutdown;
        report_t report_kind;
        voice_t  voice_kind;
        logic    rec_discard;
        logic    rec_finish;
        logic    rec_begin;
        logic    confirmed_change;
    } result_t;

    localparam int RESULT_BITS    = $bits(result_t);
    localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    // unsigned wrapping interval
    function automatic time_t elapsed(time_t now, time_t past);
        return now - past;
    endfunction

endpackage

### hw/rtl/posture_class_debounce_alarm.sv
// ---------------------------------------------------------------------------
// posture_class_debounce_alarm: posture verdict debouncer and alarm sequencer
// Confirms classifier verdicts after a hold time and raises warnings, away
// alarms and recording commands.
// ---------------------------------------------------------------------------
//  channel  | direction | content
//  s_axis   | in        | tdata[1:0] verdict, tdata[33:2] now_secs
//  m_axis   | out       | tdata[9:0] result fields, one word per input word
//  cfg      | in        | write enable, register index, 16-bit data
//
//  one input word per cycle while input is not stalled; its result goes to the result register, or to the skid stage
//  the result register and a one-word skid stage let input run on while the
//  output is stalled; input stalls only when both hold a word
//  reset clears all tracking state and loads the default thresholds
// ---------------------------------------------------------------------------
module posture_class_debounce_alarm
    import pcda_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // verdict [1:0], now_secs [33:2], zero fill above
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // confirmed_change, rec_begin, rec_finish, rec_discard, voice_kind [6:4],
    // report_kind [8:7], shutdown [9], zero fill above
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t core_result;
    result_t out_result;
    logic    accept;
    logic    space;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    // configuration registers
    pcda_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // tracking state and step logic
    pcda_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .verdict  (s_axis_tdata[VERDICT_BITS-1:0]),
        .now_secs (s_axis_tdata[IN_BITS-1:VERDICT_BITS]),
        .result   (core_result)
    );

    // result register and skid stage
    pcda_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (core_result),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'(out_result);

`ifndef SYNTH
    // a full buffer always has a word on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending output word");

    // a full buffer stays full while the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (!s_axis_tready && !m_axis_tready) |=> !s_axis_tready)
        else $error("buffer drained without an output handshake");

    // shutdown comes only with the sleep voice and away report
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_result.shutdown) |->
            (out_result.voice_kind == VOICE_SLEEP &&
             out_result.report_kind == REPORT_AWAY))
        else $error("shutdown without sleep voice and away report");

    // a confirmation never carries an alarm
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_result.confirmed_change) |->
            (!out_result.shutdown && !out_result.rec_finish))
        else $error("confirmation mixed with alarm outputs");
`endif

endmodule

### hw/rtl/pcda_cfg.sv
// ---------------------------------------------------------------------------
// pcda_cfg: configuration registers
// Four threshold registers written through a plain write port.
// ---------------------------------------------------------------------------
module pcda_cfg
    import pcda_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_hold_secs     <= MIN_HOLD_RESET;
            cfg_reg.bad_alarm_secs    <= BAD_ALARM_RESET;
            cfg_reg.repeat_alarm_secs <= REPEAT_RESET;
            cfg_reg.away_alarm_secs   <= AWAY_ALARM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_HOLD:   cfg_reg.min_hold_secs     <= cfg_data[7:0];
                CFG_BAD_ALARM:  cfg_reg.bad_alarm_secs    <= cfg_data[15:0];
                CFG_REPEAT:     cfg_reg.repeat_alarm_secs <= cfg_data[15:0];
                CFG_AWAY_ALARM: cfg_reg.away_alarm_secs   <= cfg_data[15:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/pcda_core.sv
// ---------------------------------------------------------------------------
// pcda_core: debounce and alarm state
// Holds the class tracking state and works out one result per accepted word.
// ---------------------------------------------------------------------------
module pcda_core
    import pcda_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    accept,
    input  logic [VERDICT_BITS-1:0] verdict,
    input  logic [NOW_BITS-1:0]     now_secs,
    output result_t                 result
);

    logic   seeded_reg,       seeded_next;
    class_t held_class_reg,   held_class_next;
    class_t recent_class_reg, recent_class_next;
    time_t  held_since_reg,   held_since_next;
    time_t  recent_since_reg, recent_since_next;
    time_t  last_warn_reg,    last_warn_next;
    logic   warn_first_reg,   warn_first_next;
    logic   away_first_reg,   away_first_next;
    logic   rec_active_reg,   rec_active_next;

    class_t  v;
    time_t   now;
    result_t res;

    // step logic for one word
    always_comb
    begin
        v   = class_t'(verdict);
        now = TIME_BITS'(now_secs);

        seeded_next       = seeded_reg;
        held_class_next   = held_class_reg;
        recent_class_next = recent_class_reg;
        held_since_next   = held_since_reg;
        recent_since_next = recent_since_reg;
        last_warn_next    = last_warn_reg;
        warn_first_next   = warn_first_reg;
        away_first_next   = away_first_reg;
        rec_active_next   = rec_active_reg;
        res               = '0;

        if (!seeded_reg)
        begin
            // first word only seeds the tracking state
            held_class_next   = v;
            recent_class_next = v;
            held_since_next   = now;
            recent_since_next = now;
            seeded_next       = 1'b1;
        end
        else if (held_class_reg == v)
        begin
            recent_class_next = v;
            recent_since_next = now;
            if (v == CLS_BAD)
            begin
                if (!rec_active_next)
                begin
                    res.rec_begin   = 1'b1;
                    rec_active_next = 1'b1;
                end
            end
            else if (rec_active_next)
            begin
                res.rec_discard = 1'b1;
                rec_active_next = 1'b0;
            end

            // held class persists: alarm checks
            if (v == CLS_BAD)
            begin
                if (elapsed(now, held_since_reg) >= TIME_BITS'(cfg.bad_alarm_secs))
                begin
                    if (warn_first_reg)
                    begin
                        res.voice_kind  = VOICE_WARN;
                        last_warn_next  = now;
                        warn_first_next = 1'b0;
                    end
                    else if (elapsed(now, last_warn_reg) >=
                             TIME_BITS'(cfg.repeat_alarm_secs))
                    begin
                        res.voice_kind = VOICE_WARN;
                        last_warn_next = now;
                    end
                    held_since_next = now;
                    if (rec_active_next)
                    begin
                        res.rec_finish  = 1'b1;
                        rec_active_next = 1'b0;
                    end
                    res.report_kind = REPORT_BAD;
                end
            end
            else if (v == CLS_AWAY)
            begin
                if (elapsed(now, held_since_reg) >= TIME_BITS'(cfg.away_alarm_secs))
                begin
                    if (away_first_reg)
                    begin
                        res.voice_kind  = VOICE_AWAY;
                        held_since_next = now;
                        away_first_next = 1'b0;
                    end
                    else
                    begin
                        res.voice_kind = VOICE_SLEEP;
                        res.shutdown   = 1'b1;
                    end
                    if (rec_active_next)
                    begin
                        res.rec_discard = 1'b1;
                        rec_active_next = 1'b0;
                    end
                    res.report_kind = REPORT_AWAY;
                end
            end
        end
        else if (recent_class_reg != v)
        begin
            // candidate class changes, restart its timer
            recent_class_next = v;
            recent_since_next = now;
        end
        else if (elapsed(now, recent_since_reg) >= TIME_BITS'(cfg.min_hold_secs))
        begin
            // candidate has held long enough: confirm it
            if (v == CLS_BAD)
            begin
                if (!rec_active_reg)
                begin
                    res.rec_begin   = 1'b1;
                    rec_active_next = 1'b1;
                end
            end
            else if (rec_active_reg)
            begin
                res.rec_discard = 1'b1;
                rec_active_next = 1'b0;
            end
            if (held_class_reg == CLS_BAD && v == CLS_NORMAL)
            begin
                res.voice_kind = VOICE_PRAISE;
            end
            if (held_class_reg == CLS_AWAY)
            begin
                if (!away_first_reg)
                begin
                    res.voice_kind = VOICE_REAPPEAR;
                end
                away_first_next = 1'b1;
                res.report_kind = REPORT_BACK;
            end
            held_class_next      = v;
            recent_class_next    = v;
            held_since_next      = now;
            recent_since_next    = now;
            res.confirmed_change = 1'b1;
        end
    end

    // state update on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg       <= 1'b0;
            held_class_reg   <= CLS_NORMAL;
            recent_class_reg <= CLS_NORMAL;
            held_since_reg   <= '0;
            recent_since_reg <= '0;
            last_warn_reg    <= '0;
            warn_first_reg   <= 1'b1;
            away_first_reg   <= 1'b1;
            rec_active_reg   <= 1'b0;
        end
        else if (accept)
        begin
            seeded_reg       <= seeded_next;
            held_class_reg   <= held_class_next;
            recent_class_reg <= recent_class_next;
            held_since_reg   <= held_since_next;
            recent_since_reg <= recent_since_next;
            last_warn_reg    <= last_warn_next;
            warn_first_reg   <= warn_first_next;
            away_first_reg   <= away_first_next;
            rec_active_reg   <= rec_active_next;
        end
    end

    assign result = res;

endmodule

### hw/rtl/pcda_skid.sv
// ---------------------------------------------------------------------------
// pcda_skid: result register with skid stage
// Holds computed results until the downstream side takes them.
// ---------------------------------------------------------------------------
module pcda_skid
    import pcda_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop = main_valid_reg && out_ready;

    // control: main stage feeds the port, skid catches a word under stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (load)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (load)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= load_data;
            end
            else
            begin
                main_reg <= load_data;
            end
        end
    end

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
